// ----- design/bb5_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb5_pkg: shared constants for the 5x5 rgb box blur
// Widths, line store geometry and the codes of the input kind and the
// configuration registers.
// ----------------------------------------------------------------------------
package bb5_pkg;

    // frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int W_RESET    = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int H_RESET    = 480;

    // wide enough for every position and size compare
    localparam int CMP_W = 16;

    // line store: a ring of the eight most recent rows
    localparam int RING_ROWS  = 8;
    localparam int RING_W     = $clog2(RING_ROWS);
    localparam int ADDR_W     = RING_W + COL_W;
    localparam int LINE_DEPTH = 1 << ADDR_W;

    // pixel layout
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;

    // neighbourhood: HALF rows and columns before, SPAN-1 after
    localparam int HALF     = 2;
    localparam int SPAN     = 3;
    localparam int WIN_LAST = HALF + SPAN - 1;
    localparam int WIN_W    = $clog2(WIN_LAST + 1);

    // sum of up to 25 bytes, count up to 25
    localparam int CNT_W      = $clog2((HALF + SPAN) * (HALF + SPAN) + 1);
    localparam int SUM_W      = CH_W + CNT_W;
    localparam int DIV_STEPS  = CH_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // start-up lag of 2*W+2 pixels
    localparam int LAG_W = WIDTH_W + 2;

    // input kind carried on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // configuration registers
    localparam int   CFG_ADDR_W = 1;
    localparam int   CFG_W      = 13;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 1'b1;

endpackage

// ----- design/bb5_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb5_ram: generic simple dual port ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bb5_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/box_blur_5x5_rgb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_5x5_rgb_top: 5x5 mean filter on an rgb pixel stream
// Pixels go into an eight-row line store; each result reads its window back
// tap by tap, sums per channel and divides by the count of taps in frame.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tdata red,green,blue; s_tuser kind
//  m_       out  m_tvalid/m_tready   m_tdata red,green,blue; m_tlast frame end
//  cfg_     in   cfg_wr_en           cfg_addr register, cfg_wdata value
//
//  a word that yields no result leaves the block idle
//  a word that yields a result walks through accept, 25 line store reads
//  (one read port, one tap a cycle), a drain of the read, 8 divide steps
//  and the load of the output register
//  a waiting result holds the block until m_tready; the input side stays
//  ready while the output register is full and the block is idle
//  reset is synchronous; the line store needs no clearing pass
// ----------------------------------------------------------------------------
module box_blur_5x5_rgb_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bb5_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bb5_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // red_in, green_in, blue_in
    input  logic                              s_tuser,   // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // red_out, green_out, blue_out
    output logic                              m_tlast    // frame_done
);

    localparam int COL_W  = bb5_pkg::COL_W;
    localparam int ROW_W  = bb5_pkg::ROW_W;
    localparam int CMP_W  = bb5_pkg::CMP_W;
    localparam int RR_W   = ROW_W + 2;
    localparam int CC_W   = COL_W + 2;
    localparam int SUM_W  = bb5_pkg::SUM_W;
    localparam int CNT_W  = bb5_pkg::CNT_W;
    localparam int CH_W   = bb5_pkg::CH_W;
    localparam int NUM_CH = bb5_pkg::NUM_CH;
    localparam int LAG_W  = bb5_pkg::LAG_W;
    localparam int WIN_W  = bb5_pkg::WIN_W;
    localparam int DCW    = bb5_pkg::DIV_CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FLUSH,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t                          state_reg, state_next;
    logic [bb5_pkg::WIDTH_W-1:0]     w_reg, w_next;
    logic [bb5_pkg::HEIGHT_W-1:0]    h_reg, h_next;
    logic [COL_W-1:0]                in_col_reg, in_col_next;
    logic [ROW_W-1:0]                in_row_reg, in_row_next;
    logic                            in_full_reg, in_full_next;
    logic [LAG_W-1:0]                pos_reg, pos_next;
    logic [COL_W-1:0]                out_col_reg, out_col_next;
    logic [ROW_W-1:0]                out_row_reg, out_row_next;
    logic [WIN_W-1:0]                win_r_reg, win_r_next;
    logic [WIN_W-1:0]                win_c_reg, win_c_next;
    logic                            rd_tag_reg, rd_tag_next;
    logic [SUM_W-1:0]                acc_reg [NUM_CH];
    logic [SUM_W-1:0]                acc_next [NUM_CH];
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [DCW-1:0]                  div_cnt_reg, div_cnt_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [bb5_pkg::PIX_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                            m_tlast_reg, m_tlast_next;

    logic                            accept;
    logic                            pix_take;
    logic                            start;
    logic [LAG_W-1:0]                lag;
    logic                            col_wrap;
    logic                            row_wrap;
    logic [RR_W-1:0]                 rr;
    logic [CC_W-1:0]                 cc;
    logic                            tap_ok;
    logic [bb5_pkg::ADDR_W-1:0]      rd_addr;
    logic [bb5_pkg::ADDR_W-1:0]      wr_addr;
    logic [bb5_pkg::PIX_W-1:0]       rd_data;
    logic                            out_free;
    logic                            frame_end;
    logic                            restart;
    logic [SUM_W-1:0]                acc_sum [NUM_CH];
    logic [SUM_W-1:0]                acc_div [NUM_CH];
    logic [CNT_W:0]                  div_t [NUM_CH];
    logic                            div_ge [NUM_CH];
    logic [CNT_W:0]                  div_r [NUM_CH];
    logic [bb5_pkg::WIDTH_W-1:0]     w_clamp;
    logic [bb5_pkg::HEIGHT_W-1:0]    h_clamp;

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pix_take = accept && (s_tuser == bb5_pkg::OP_PIXEL) && !in_full_reg;
    assign lag      = {1'b0, w_reg, 1'b0} + LAG_W'(2);
    assign start    = (pix_take && (pos_reg >= lag))
                   || (accept && (s_tuser == bb5_pkg::OP_DRAIN) && in_full_reg);
    assign col_wrap = (CMP_W'(in_col_reg) + CMP_W'(1)) >= CMP_W'(w_reg);
    assign row_wrap = (CMP_W'(in_row_reg) + CMP_W'(1)) >= CMP_W'(h_reg);
    assign wr_addr  = {in_row_reg[bb5_pkg::RING_W-1:0], in_col_reg};

    // ------------------------------------------------------------------
    // window tap address; a negative coordinate shows in the top bit
    // ------------------------------------------------------------------
    assign rr = RR_W'(out_row_reg) + RR_W'(win_r_reg) - RR_W'(bb5_pkg::HALF);
    assign cc = CC_W'(out_col_reg) + CC_W'(win_c_reg) - CC_W'(bb5_pkg::HALF);
    assign tap_ok = !rr[RR_W-1] && (CMP_W'(rr[RR_W-2:0]) < CMP_W'(h_reg))
                 && !cc[CC_W-1] && (CMP_W'(cc[CC_W-2:0]) < CMP_W'(w_reg));
    assign rd_addr     = {rr[bb5_pkg::RING_W-1:0], cc[COL_W-1:0]};
    assign rd_tag_next = (state_reg == ST_READ) && tap_ok;

    // the pixel is written on the accept cycle, reads only start after it,
    // so the sequencer itself keeps reads and writes of one entry apart
    bb5_ram #(
        .WIDTH (bb5_pkg::PIX_W),
        .DEPTH (bb5_pkg::LINE_DEPTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (pix_take),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // per channel sum and restoring divide step
    // acc holds {remainder, dividend/quotient} while dividing
    // ------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            acc_sum[c] = acc_reg[c] + SUM_W'(rd_data[c*CH_W +: CH_W]);
            div_t[c]   = {acc_reg[c][SUM_W-1:CH_W], acc_reg[c][CH_W-1]};
            div_ge[c]  = div_t[c] >= {1'b0, cnt_reg};
            div_r[c]   = div_ge[c] ? (div_t[c] - {1'b0, cnt_reg}) : div_t[c];
            acc_div[c] = {div_r[c][CNT_W-1:0], acc_reg[c][CH_W-2:0], div_ge[c]};
        end
    end

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    assign out_free  = !m_tvalid_reg || m_tready;
    assign frame_end = ((CMP_W'(out_row_reg) + CMP_W'(1)) == CMP_W'(h_reg))
                    && ((CMP_W'(out_col_reg) + CMP_W'(1)) == CMP_W'(w_reg));
    assign restart   = cfg_wr_en || ((state_reg == ST_HOLD) && out_free && frame_end);

    always_comb begin
        if (cfg_wdata[bb5_pkg::WIDTH_W-1:0] == '0) begin
            w_clamp = bb5_pkg::WIDTH_W'(1);
        end else if (CMP_W'(cfg_wdata[bb5_pkg::WIDTH_W-1:0]) > CMP_W'(bb5_pkg::MAX_WIDTH)) begin
            w_clamp = bb5_pkg::WIDTH_W'(bb5_pkg::MAX_WIDTH);
        end else begin
            w_clamp = cfg_wdata[bb5_pkg::WIDTH_W-1:0];
        end
        if (cfg_wdata[bb5_pkg::HEIGHT_W-1:0] == '0) begin
            h_clamp = bb5_pkg::HEIGHT_W'(1);
        end else if (CMP_W'(cfg_wdata[bb5_pkg::HEIGHT_W-1:0]) > CMP_W'(bb5_pkg::MAX_HEIGHT)) begin
            h_clamp = bb5_pkg::HEIGHT_W'(bb5_pkg::MAX_HEIGHT);
        end else begin
            h_clamp = cfg_wdata[bb5_pkg::HEIGHT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_full_next  = in_full_reg;
        pos_next      = pos_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        win_r_next    = win_r_reg;
        win_c_next    = win_c_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        div_cnt_next  = div_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (pix_take) begin
                    if (col_wrap) begin
                        in_col_next = '0;
                        if (row_wrap) begin
                            in_row_next  = '0;
                            in_full_next = 1'b1;
                        end else begin
                            in_row_next = in_row_reg + ROW_W'(1);
                        end
                    end else begin
                        in_col_next = in_col_reg + COL_W'(1);
                    end
                    if (pos_reg < lag) begin
                        pos_next = pos_reg + LAG_W'(1);
                    end
                end
                if (start) begin
                    state_next = ST_READ;
                    win_r_next = '0;
                    win_c_next = '0;
                    cnt_next   = '0;
                    for (int c = 0; c < NUM_CH; c++) begin
                        acc_next[c] = '0;
                    end
                end
            end
            ST_READ: begin
                if (rd_tag_reg) begin
                    acc_next = acc_sum;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (win_c_reg == WIN_W'(bb5_pkg::WIN_LAST)) begin
                    win_c_next = '0;
                    if (win_r_reg == WIN_W'(bb5_pkg::WIN_LAST)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        win_r_next = win_r_reg + WIN_W'(1);
                    end
                end else begin
                    win_c_next = win_c_reg + WIN_W'(1);
                end
            end
            ST_FLUSH: begin
                if (rd_tag_reg) begin
                    acc_next = acc_sum;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                acc_next     = acc_div;
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(bb5_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = frame_end;
                    for (int c = 0; c < NUM_CH; c++) begin
                        m_tdata_next[c*CH_W +: CH_W] = acc_reg[c][CH_W-1:0];
                    end
                    if ((CMP_W'(out_col_reg) + CMP_W'(1)) >= CMP_W'(w_reg)) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (restart) begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_full_next = 1'b0;
            pos_next     = '0;
            out_col_next = '0;
            out_row_next = '0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                bb5_pkg::REG_WIDTH:  w_next = w_clamp;
                bb5_pkg::REG_HEIGHT: h_next = h_clamp;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            w_reg        <= bb5_pkg::WIDTH_W'(bb5_pkg::W_RESET);
            h_reg        <= bb5_pkg::HEIGHT_W'(bb5_pkg::H_RESET);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_full_reg  <= 1'b0;
            pos_reg      <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            rd_tag_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            w_reg        <= w_next;
            h_reg        <= h_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_full_reg  <= in_full_next;
            pos_reg      <= pos_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            rd_tag_reg   <= rd_tag_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        win_r_reg   <= win_r_next;
        win_c_reg   <= win_c_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        div_cnt_reg <= div_cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- design/bb5_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb5_checker: port level checks for the 5x5 rgb box blur
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module bb5_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [23:0]                       m_tdata,
    input logic                              m_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // reset empties the output register
    a_out_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a result needs the window walk, never appears the cycle after an accept
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared straight after an accepted word");

    // a new result is loaded only as the busy block returns to idle
    a_load_at_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready && !$past(s_tready))
        else $error("result loaded outside the end of a window walk");

endmodule

bind box_blur_5x5_rgb_top bb5_checker u_bb5_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

// ----- sim/box_blur_5x5_rgb_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_5x5_rgb_top_test: self-checking bench for the 5x5 rgb box blur
// Frames of random size and content are streamed in, with stray drain ticks
// and pixels mixed in. Each accepted word goes through a local blur predictor
// and every result word is compared with the oldest expected pixel.
// ----------------------------------------------------------------------------
module box_blur_5x5_rgb_top_test;
    import bb5_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 50;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_WORDS  = 400;
    localparam int CALM_AFTER    = 360;

    // same layout as tdata: red in the lowest byte
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    typedef struct {
        logic op;
        rgb_t pix;
    } word_t;

    typedef struct {
        rgb_t pix;
        logic last;
    } blurred_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tlast;

    word_t    pixel_q[$];
    blurred_t blurred_q[$];
    word_t    cur_word;
    int       src_gap   = 0;
    int       sink_gap  = 0;
    int       hold_left = 0;
    bit       hold_req  = 1'b0;
    bit       calm      = 1'b0;
    int       words_sent = 0;
    int       fail_cnt  = 0;
    int       cycle_cnt = 0;

    // predictor state
    rgb_t                line_mem [RING_ROWS*MAX_WIDTH];
    logic [WIDTH_W-1:0]  pw     = WIDTH_W'(W_RESET);
    logic [HEIGHT_W-1:0] ph     = HEIGHT_W'(H_RESET);
    logic [ROW_W-1:0]    wr_row = '0;
    logic [ROW_W-1:0]    rd_row = '0;
    logic [COL_W-1:0]    wr_col = '0;
    logic [COL_W-1:0]    rd_col = '0;
    bit                  in_done = 1'b0;

    box_blur_5x5_rgb_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        wr_row  = '0;
        wr_col  = '0;
        rd_row  = '0;
        rd_col  = '0;
        in_done = 1'b0;
    endfunction

    // truncated mean over the taps of the 5x5 window that fall inside the frame
    function automatic rgb_t window_mean(int r, int c);
        int   sr, sg, sb, n, rr, cc, dr, dc;
        rgb_t px;
        rgb_t m;
        sr = 0;
        sg = 0;
        sb = 0;
        n  = 0;
        for (dr = -HALF; dr < SPAN; dr++) begin
            rr = r + dr;
            if (rr < 0 || rr >= int'(ph)) continue;
            for (dc = -HALF; dc < SPAN; dc++) begin
                cc = c + dc;
                if (cc < 0 || cc >= int'(pw)) continue;
                px = line_mem[ADDR_W'((rr % RING_ROWS) * MAX_WIDTH + cc)];
                sr += px.red;
                sg += px.green;
                sb += px.blue;
                n++;
            end
        end
        if (n == 0) n = 1;
        m.red   = CH_W'(sr / n);
        m.green = CH_W'(sg / n);
        m.blue  = CH_W'(sb / n);
        return m;
    endfunction

    function automatic blurred_t next_blurred();
        blurred_t b;
        b.pix  = window_mean(int'(rd_row), int'(rd_col));
        b.last = (int'(rd_row) == int'(ph) - 1) && (int'(rd_col) == int'(pw) - 1);
        if (b.last) begin
            restart_frame();
        end else if (int'(rd_col) + 1 >= int'(pw)) begin
            rd_col = '0;
            rd_row = rd_row + ROW_W'(1);
        end else begin
            rd_col = rd_col + COL_W'(1);
        end
        return b;
    endfunction

    // returns 1 when the word yields a blurred pixel
    function automatic bit blur_step(word_t wd, output blurred_t res);
        int pos, lag;
        if (wd.op == OP_PIXEL) begin
            if (in_done) return 1'b0;
            line_mem[ADDR_W'((int'(wr_row) % RING_ROWS) * MAX_WIDTH + int'(wr_col))] = wd.pix;
            pos = int'(wr_row) * int'(pw) + int'(wr_col);
            lag = 2 * int'(pw) + 2;
            if (int'(wr_col) + 1 >= int'(pw)) begin
                wr_col = '0;
                if (int'(wr_row) + 1 >= int'(ph)) begin
                    in_done = 1'b1;
                    wr_row  = '0;
                end else begin
                    wr_row = wr_row + ROW_W'(1);
                end
            end else begin
                wr_col = wr_col + COL_W'(1);
            end
            if (pos < lag) return 1'b0;
            res = next_blurred();
            return 1'b1;
        end
        if (!in_done) return 1'b0;
        res = next_blurred();
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        fail_cnt++;
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_WIDTH) begin
            pw = WIDTH_W'(clamp_dim(value & ((1 << WIDTH_W) - 1), MAX_WIDTH));
        end else begin
            ph = HEIGHT_W'(clamp_dim(value & ((1 << HEIGHT_W) - 1), MAX_HEIGHT));
        end
        restart_frame();
    endtask

    // wait until every word is in and every result is out, then let it settle
    task automatic settle();
        while (pixel_q.size() != 0 || s_tvalid || blurred_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [CH_W-1:0] rand_ch();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return CH_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    function automatic rgb_t rand_pix();
        rgb_t p;
        p.red   = rand_ch();
        p.green = rand_ch();
        p.blue  = rand_ch();
        return p;
    endfunction

    function automatic void queue_word(logic op, rgb_t pix);
        word_t wd;
        wd.op  = op;
        wd.pix = pix;
        pixel_q.push_back(wd);
        words_sent++;
    endfunction

    // a frame of w x h pixels; stops after keep pixels if that is short of the frame
    function automatic void queue_frame(int w, int h, int keep, bit noisy);
        int npix, ndrain, i;
        npix   = w * h;
        ndrain = (npix > 2 * w + 2) ? 2 * w + 2 : npix;
        for (i = 0; i < npix && i < keep; i++) begin
            // drain tick while pixels are still due is ignored
            if (noisy && $urandom_range(0, 15) == 0) queue_word(OP_DRAIN, rand_pix());
            queue_word(OP_PIXEL, rand_pix());
        end
        if (keep < npix) return;
        for (i = 0; i < ndrain; i++) begin
            // frame already full: stray pixel is ignored
            if (noisy && $urandom_range(0, 7) == 0) queue_word(OP_PIXEL, rand_pix());
            queue_word(OP_DRAIN, rand_pix());
        end
        if (noisy && $urandom_range(0, 3) == 0) queue_word(OP_DRAIN, rand_pix());
    endfunction

    // sender: predicts on every accepted word
    always @(posedge aclk) begin
        blurred_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (blur_step(cur_word, res)) blurred_q.push_back(res);
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    cur_word = pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_word.pix;
                    s_tuser  <= cur_word.op;
                    if (!calm && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall bursts plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        blurred_t want;
        rgb_t     got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (blurred_q.size() == 0) begin
                report_mismatch("word with nothing due", int'(m_tdata), 0);
            end else begin
                want = blurred_q.pop_front();
                if (got.red !== want.pix.red)
                    report_mismatch("red", int'(got.red), int'(want.pix.red));
                if (got.green !== want.pix.green)
                    report_mismatch("green", int'(got.green), int'(want.pix.green));
                if (got.blue !== want.pix.blue)
                    report_mismatch("blue", int'(got.blue), int'(want.pix.blue));
                if (m_tlast !== want.last)
                    report_mismatch("frame end", int'(m_tlast), int'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int w, h, frame_no, stop_at;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // single pixel frame; zero sizes clamp to one
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        queue_word(OP_DRAIN, '0);
        queue_word(OP_PIXEL, '1);
        queue_word(OP_PIXEL, '0);
        queue_word(OP_DRAIN, '0);
        queue_word(OP_DRAIN, '1);
        settle();

        // 2x2: too small for the start-up lag, every result comes from a drain tick
        write_reg(REG_WIDTH, 2);
        write_reg(REG_HEIGHT, 2);
        queue_word(OP_PIXEL, '1);
        queue_word(OP_PIXEL, 24'h0000FF);
        queue_word(OP_PIXEL, 24'hFF0000);
        queue_word(OP_PIXEL, 24'h00FF00);
        repeat (4) queue_word(OP_DRAIN, '0);
        settle();

        // tallest frame, one column, cut short by the next write
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, (1 << CFG_W) - 1);
        queue_frame(1, MAX_HEIGHT, 10, 1'b0);
        settle();

        // widest frame, also cut short
        write_reg(REG_WIDTH, (1 << CFG_W) - 1);
        write_reg(REG_HEIGHT, 1);
        queue_frame(MAX_WIDTH, 1, 3, 1'b0);
        settle();

        frame_no = 0;
        stop_at  = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            if (words_sent >= stop_at - RANDOM_WORDS + CALM_AFTER) calm = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                w = $urandom_range(9, 40);
                h = $urandom_range(1, 3);
            end else begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 8);
            end
            if (frame_no == 2) begin
                w = 7;
                h = 6;
            end
            // upper bits of the width word are dropped by the block
            write_reg(REG_WIDTH, w | ($urandom_range(0, 3) << WIDTH_W));
            write_reg(REG_HEIGHT, h);
            // long hold-off so the result path backs up into the input
            if (frame_no == 2) hold_req = 1'b1;
            queue_frame(w, h, ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h) : w * h,
                        1'b1);
            settle();
            frame_no++;
        end

        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- box_blur_5x5_rgb_top.f -----
design/bb5_pkg.sv
design/bb5_ram.sv
design/box_blur_5x5_rgb_top.sv
design/bb5_checker.sv
sim/box_blur_5x5_rgb_top_test.sv
